FILE: rtl/core/afp_pkg.sv
// afp_pkg: shared types and constants of the array focusing phase block
// no dependencies; used by every module of the block
`default_nettype none

package afp_pkg;

    // array size and field widths
    localparam int MaxElements = 512;
    localparam int IndexW      = 9;
    localparam int CoordW      = 16;
    localparam int CountW      = 10;
    localparam int InvW        = 24;
    localparam int AmpW        = 8;
    localparam int PhaseW      = 16;

    // distance path widths
    localparam int DiffW   = CoordW + 1;           // element minus focus
    localparam int SqW     = 2 * CoordW;           // one squared difference
    localparam int SumW    = SqW + 2;              // sum of three squares
    localparam int FracW   = 16;                   // radicand scaled by 2^16
    localparam int RadW    = SumW + FracW;         // 50-bit radicand
    localparam int RootW   = RadW / 2;             // 25-bit root
    localparam int RemW    = RootW + 2;            // remainder of one root step
    localparam int CurW    = RemW + 2;             // remainder with next digit

    // multiplier split of the root into two partial products
    localparam int RootLoW = 12;
    localparam int RootHiW = RootW - RootLoW;
    localparam int LoProdW = RootLoW + InvW;
    localparam int HiProdW = RootHiW + InvW;
    localparam int AccW    = 40;                   // product kept modulo one turn, in 2^-40 turn
    localparam int RoundShift = AccW - PhaseW;     // 24

    localparam logic [PhaseW-1:0] HalfTurn = 16'h8000;
    localparam logic [AccW-1:0]   RoundHalf = 40'h00_0080_0000;

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 24;
    localparam logic [CfgIdxW-1:0] RegFocusX    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegFocusY    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFocusZ    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegInvWave   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegTwinMode  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegElemCount = 3'd5;
    localparam logic [CfgIdxW-1:0] RegDriveAmp  = 3'd6;

    // reset values of the configuration registers
    localparam logic signed [CoordW-1:0] FocusXReset = 16'sd0;
    localparam logic signed [CoordW-1:0] FocusYReset = 16'sd0;
    localparam logic signed [CoordW-1:0] FocusZReset = 16'sd3277;
    localparam logic [InvW-1:0]          InvReset    = 24'd7642675;
    localparam logic [CountW-1:0]        CountReset  = 10'd256;
    localparam logic [AmpW-1:0]          AmpReset    = 8'd255;
    localparam logic [CountW-1:0]        CountMax    = CountW'(MaxElements);

    typedef struct packed {
        logic [IndexW-1:0]        elem_index;
        logic signed [CoordW-1:0] elem_x;
        logic signed [CoordW-1:0] elem_y;
        logic signed [CoordW-1:0] elem_z;
    } t_in_word;

    typedef struct packed {
        logic [IndexW-1:0] index_out;
        logic [PhaseW-1:0] phase_out;
        logic [AmpW-1:0]   amplitude_out;
    } t_out_word;

    // side data that rides along with each word through the chain
    typedef struct packed {
        logic [IndexW-1:0] index;
        logic              half_turn;
        logic [AmpW-1:0]   amp;
    } t_tag;

    // what one root cell hands to the next
    typedef struct packed {
        logic [RadW-1:0]  radicand;
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_root_state;

endpackage

`default_nettype wire

FILE: rtl/core/afp_dist_sq.sv
// afp_dist_sq: squared distance from element to focal point, three stages
// depends on afp_pkg
`default_nettype none

module afp_dist_sq (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  wire                                   i_valid,
    input  afp_pkg::t_in_word                     i_word,
    input  afp_pkg::t_tag                         i_tag,
    input  wire signed [afp_pkg::CoordW-1:0]      i_focus_x,
    input  wire signed [afp_pkg::CoordW-1:0]      i_focus_y,
    input  wire signed [afp_pkg::CoordW-1:0]      i_focus_z,
    output logic                                  o_valid,
    output afp_pkg::t_tag                         o_tag,
    output logic [afp_pkg::SumW-1:0]              o_sum
);

    logic signed [afp_pkg::DiffW-1:0] r_dx, r_dy, r_dz;
    logic [afp_pkg::SqW-1:0]          r_sqx, r_sqy, r_sqz;
    logic [afp_pkg::SumW-1:0]         r_sum;
    afp_pkg::t_tag                    r_tag0, r_tag1, r_tag2;
    logic                             r_v0, r_v1, r_v2;

    logic signed [afp_pkg::DiffW-1:0]   n_dx, n_dy, n_dz;
    logic signed [2*afp_pkg::DiffW-1:0] n_px, n_py, n_pz;
    logic [afp_pkg::SumW-1:0]           n_sum;

    always_comb begin
        n_dx = {i_word.elem_x[afp_pkg::CoordW-1], i_word.elem_x}
             - {i_focus_x[afp_pkg::CoordW-1], i_focus_x};
        n_dy = {i_word.elem_y[afp_pkg::CoordW-1], i_word.elem_y}
             - {i_focus_y[afp_pkg::CoordW-1], i_focus_y};
        n_dz = {i_word.elem_z[afp_pkg::CoordW-1], i_word.elem_z}
             - {i_focus_z[afp_pkg::CoordW-1], i_focus_z};
        n_px = r_dx * r_dx;
        n_py = r_dy * r_dy;
        n_pz = r_dz * r_dz;
        n_sum = {2'b00, r_sqx} + {2'b00, r_sqy} + {2'b00, r_sqz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dz   <= n_dz;
            r_tag0 <= i_tag;
            // squares of values below 2^16 in magnitude fit in 32 bits
            r_sqx  <= n_px[afp_pkg::SqW-1:0];
            r_sqy  <= n_py[afp_pkg::SqW-1:0];
            r_sqz  <= n_pz[afp_pkg::SqW-1:0];
            r_tag1 <= r_tag0;
            r_sum  <= n_sum;
            r_tag2 <= r_tag1;
        end
    end

    assign o_valid = r_v2;
    assign o_tag   = r_tag2;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

FILE: rtl/core/afp_root_cell.sv
// afp_root_cell: one digit step of the integer square root, registered
// depends on afp_pkg
`default_nettype none

module afp_root_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  afp_pkg::t_tag        i_tag,
    input  afp_pkg::t_root_state i_state,
    output logic                 o_valid,
    output afp_pkg::t_tag        o_tag,
    output afp_pkg::t_root_state o_state
);

    logic                         r_valid;
    afp_pkg::t_tag                r_tag;
    afp_pkg::t_root_state         r_state;

    logic [afp_pkg::CurW-1:0]     n_cur;
    logic [afp_pkg::CurW-1:0]     n_trial;
    logic [afp_pkg::CurW-1:0]     n_diff;
    logic                         n_ge;
    afp_pkg::t_root_state         n_state;

    // bring down the next two radicand bits and try a one in the root
    always_comb begin
        n_cur   = {i_state.rem, i_state.radicand[afp_pkg::RadW-1 -: 2]};
        n_trial = {2'b00, i_state.root, 2'b01};
        n_ge    = (n_cur >= n_trial);
        n_diff  = n_ge ? (n_cur - n_trial) : n_cur;
        n_state.radicand = {i_state.radicand[afp_pkg::RadW-3:0], 2'b00};
        n_state.rem      = n_diff[afp_pkg::RemW-1:0];
        n_state.root     = {i_state.root[afp_pkg::RootW-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag   <= i_tag;
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_state = r_state;

endmodule

`default_nettype wire

FILE: rtl/core/afp_phase.sv
// afp_phase: distance times inverse wavelength, rounding, wrap and output register
// depends on afp_pkg
`default_nettype none

module afp_phase (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  afp_pkg::t_tag                  i_tag,
    input  wire [afp_pkg::RootW-1:0]       i_root,
    input  wire [afp_pkg::InvW-1:0]        i_inv_wavelength,
    output logic                           o_valid,
    output afp_pkg::t_out_word             o_word
);

    logic [afp_pkg::LoProdW-1:0] r_lo;
    logic [afp_pkg::HiProdW-1:0] r_hi;
    logic [afp_pkg::PhaseW-1:0]  r_path;
    afp_pkg::t_tag               r_tag1, r_tag2;
    afp_pkg::t_out_word          r_word;
    logic                        r_v1, r_v2, r_v3;

    logic [afp_pkg::LoProdW-1:0] n_lo;
    logic [afp_pkg::HiProdW-1:0] n_hi;
    logic [afp_pkg::AccW-1:0]    n_acc;
    logic [afp_pkg::PhaseW-1:0]  n_sig;

    always_comb begin
        n_lo  = i_root[afp_pkg::RootLoW-1:0] * i_inv_wavelength;
        n_hi  = i_root[afp_pkg::RootW-1:afp_pkg::RootLoW] * i_inv_wavelength;
        // product kept modulo one turn at 2^-40 resolution, rounded half up
        n_acc = {{(afp_pkg::AccW - afp_pkg::LoProdW){1'b0}}, r_lo}
              + {r_hi[afp_pkg::AccW-afp_pkg::RootLoW-1:0], {afp_pkg::RootLoW{1'b0}}}
              + afp_pkg::RoundHalf;
        n_sig = r_tag2.half_turn ? afp_pkg::HalfTurn : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_tag1 <= i_tag;
            r_path <= n_acc[afp_pkg::AccW-1:afp_pkg::RoundShift];
            r_tag2 <= r_tag1;
            r_word.index_out     <= r_tag2.index;
            r_word.phase_out     <= n_sig - r_path;
            r_word.amplitude_out <= r_tag2.amp;
        end
    end

    assign o_valid = r_v3;
    assign o_word  = r_word;

endmodule

`default_nettype wire

FILE: rtl/core/array_focus_phase.sv
// array_focus_phase: top level, configuration registers, input skid and root chain
// depends on afp_pkg, afp_dist_sq, afp_root_cell, afp_phase
`default_nettype none

// Focusing phase for one element of an ultrasonic phased array. Each input
// word carries an element index and its x, y, z position in units of 2^-16 m;
// the block finds the distance to the focal point, scales it by the inverse
// wavelength into turns (rounded to 2^-16 turn), adds half a turn in twin mode
// for elements at or above half the clamped element count, and returns the
// negated phase wrapped to one turn with the drive amplitude. One word is
// accepted and one result delivered every clock cycle while the output is
// not stalled; from acceptance to the output register each word runs mostly
// through the row of 25 square-root cells (one root bit per cell). The
// distance path runs three stages (difference, squares, sum) and the phase
// path three (partial products, rounding, wrap). A two-entry arrangement of
// skid register plus chain lets o_stall come from a flop. Configuration is
// written through i_cfg_we / i_cfg_index / i_cfg_wdata while no word is in
// flight, which the block does not enforce; unknown indexes are ignored.

module array_focus_phase (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input words
    input  wire                              i_valid,
    output logic                             o_stall,
    input  afp_pkg::t_in_word                i_data,
    // result words
    output logic                             o_valid,
    input  wire                              i_stall,
    output afp_pkg::t_out_word               o_data,
    // configuration writes
    input  wire                              i_cfg_we,
    input  wire [afp_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire [afp_pkg::CfgDataW-1:0]      i_cfg_wdata
);

    // configuration registers
    logic signed [afp_pkg::CoordW-1:0] r_focus_x;
    logic signed [afp_pkg::CoordW-1:0] r_focus_y;
    logic signed [afp_pkg::CoordW-1:0] r_focus_z;
    logic [afp_pkg::InvW-1:0]          r_inv_wavelength;
    logic                              r_twin_mode;
    logic [afp_pkg::CountW-1:0]        r_element_count;
    logic [afp_pkg::AmpW-1:0]          r_drive_amplitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_x         <= afp_pkg::FocusXReset;
            r_focus_y         <= afp_pkg::FocusYReset;
            r_focus_z         <= afp_pkg::FocusZReset;
            r_inv_wavelength  <= afp_pkg::InvReset;
            r_twin_mode       <= 1'b0;
            r_element_count   <= afp_pkg::CountReset;
            r_drive_amplitude <= afp_pkg::AmpReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afp_pkg::RegFocusX:    r_focus_x <= i_cfg_wdata[afp_pkg::CoordW-1:0];
                afp_pkg::RegFocusY:    r_focus_y <= i_cfg_wdata[afp_pkg::CoordW-1:0];
                afp_pkg::RegFocusZ:    r_focus_z <= i_cfg_wdata[afp_pkg::CoordW-1:0];
                afp_pkg::RegInvWave:   r_inv_wavelength <= i_cfg_wdata[afp_pkg::InvW-1:0];
                afp_pkg::RegTwinMode:  r_twin_mode <= i_cfg_wdata[0];
                afp_pkg::RegElemCount: r_element_count <= i_cfg_wdata[afp_pkg::CountW-1:0];
                afp_pkg::RegDriveAmp:  r_drive_amplitude <= i_cfg_wdata[afp_pkg::AmpW-1:0];
                default: begin
                end
            endcase
        end
    end

    // whole pipeline moves together unless the output word is held
    logic chain_en;
    assign chain_en = !(o_valid && i_stall);

    // skid register: catches the word accepted in a cycle the chain stood still
    logic              r_skid_valid;
    afp_pkg::t_in_word r_skid;
    logic              in_accept;
    logic              head_valid;
    afp_pkg::t_in_word head_word;

    assign o_stall    = r_skid_valid;
    assign in_accept  = i_valid && !r_skid_valid;
    assign head_valid = r_skid_valid || in_accept;
    assign head_word  = r_skid_valid ? r_skid : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (chain_en) begin
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!chain_en && in_accept) begin
            r_skid <= i_data;
        end
    end

    // twin half decision: count clamped to the array size, then halved
    logic [afp_pkg::CountW-1:0] n_clamped;
    logic [afp_pkg::CountW-1:0] n_half;
    afp_pkg::t_tag              head_tag;

    always_comb begin
        n_clamped = (r_element_count > afp_pkg::CountMax) ? afp_pkg::CountMax
                                                          : r_element_count;
        n_half    = n_clamped >> 1;
        head_tag.index     = head_word.elem_index;
        head_tag.half_turn = r_twin_mode
            && ({{(afp_pkg::CountW - afp_pkg::IndexW){1'b0}}, head_word.elem_index} >= n_half);
        head_tag.amp       = r_drive_amplitude;
    end

    // squared distance
    logic                        sq_valid;
    afp_pkg::t_tag               sq_tag;
    logic [afp_pkg::SumW-1:0]    sq_sum;

    afp_dist_sq u_dist_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (chain_en),
        .i_valid   (head_valid),
        .i_word    (head_word),
        .i_tag     (head_tag),
        .i_focus_x (r_focus_x),
        .i_focus_y (r_focus_y),
        .i_focus_z (r_focus_z),
        .o_valid   (sq_valid),
        .o_tag     (sq_tag),
        .o_sum     (sq_sum)
    );

    // row of root cells, one root bit each; radicand is the sum scaled by 2^16
    logic                 cell_valid [afp_pkg::RootW+1];
    afp_pkg::t_tag        cell_tag   [afp_pkg::RootW+1];
    afp_pkg::t_root_state cell_state [afp_pkg::RootW+1];

    assign cell_valid[0]          = sq_valid;
    assign cell_tag[0]            = sq_tag;
    assign cell_state[0].radicand = {sq_sum, {afp_pkg::FracW{1'b0}}};
    assign cell_state[0].rem      = '0;
    assign cell_state[0].root     = '0;

    for (genvar k = 0; k < afp_pkg::RootW; k++) begin : g_root
        afp_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_valid (cell_valid[k]),
            .i_tag   (cell_tag[k]),
            .i_state (cell_state[k]),
            .o_valid (cell_valid[k+1]),
            .o_tag   (cell_tag[k+1]),
            .o_state (cell_state[k+1])
        );
    end

    // phase scaling and output register
    afp_phase u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (chain_en),
        .i_valid          (cell_valid[afp_pkg::RootW]),
        .i_tag            (cell_tag[afp_pkg::RootW]),
        .i_root           (cell_state[afp_pkg::RootW].root),
        .i_inv_wavelength (r_inv_wavelength),
        .o_valid          (o_valid),
        .o_word           (o_data)
    );

endmodule

`default_nettype wire

FILE: sim/array_focus_phase_tb.sv
`timescale 1ns / 1ps
// array_focus_phase_tb: self-checking bench for the array focusing phase block
// depends on afp_pkg and array_focus_phase; predicts every result word in-bench

module array_focus_phase_tb;
    import afp_pkg::*;

    // index with no register behind it, writes there must change nothing
    localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
    localparam int InW           = $bits(t_in_word);
    localparam int SettleCycles  = 40;      // outlasts the pipe from input to result
    localparam int SetupCount    = 8;
    localparam int WordsPerSetup = 250;
    localparam int GridPitch     = 655;     // about 10 mm in 2^-16 m

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_COMB
    } t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_word            i_data;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_out_word           o_data;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_wdata;

    // bench copy of the configuration registers
    logic signed [CoordW-1:0] focal_x;
    logic signed [CoordW-1:0] focal_y;
    logic signed [CoordW-1:0] focal_z;
    logic [InvW-1:0]          turns_per_m;
    logic                     twin_on;
    logic [CountW-1:0]        elem_count;
    logic [AmpW-1:0]          drive_amp;

    // predicted result words, oldest first
    t_out_word pending_phases[$];

    int fail_count      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int half_turn_words = 0;
    int setups_written  = 0;

    t_stall_mode stall_mode = STALL_NONE;
    logic [15:0] stall_tick = '0;

    array_focus_phase dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // twin trap: elements at or above half the clamped count get half a turn
    function automatic logic in_upper_half(input logic [IndexW-1:0] idx);
        int n;
        n = (int'(elem_count) > MaxElements) ? MaxElements : int'(elem_count);
        return twin_on && (int'(idx) >= n / 2);
    endfunction

    function automatic t_out_word focus_phase(input t_in_word w);
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] radicand;
        logic [63:0] dist_root;
        logic [63:0] trial;
        logic [63:0] path;
        logic [63:0] rounded;
        t_out_word   r;
        dx = longint'($signed(w.elem_x)) - longint'($signed(focal_x));
        dy = longint'($signed(w.elem_y)) - longint'($signed(focal_y));
        dz = longint'($signed(w.elem_z)) - longint'($signed(focal_z));
        // squared distance scaled by 2^16 so the root lands in 2^-24 m
        radicand = 64'(dx * dx + dy * dy + dz * dz) << FracW;
        // floor square root, one bit at a time from the top
        dist_root = '0;
        for (int b = 25; b >= 0; b--) begin
            trial = dist_root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                dist_root = trial;
            end
        end
        // 2^-40 turn product, rounded half up to 2^-16 turn
        path    = dist_root * 64'(turns_per_m);
        rounded = (path + 64'(RoundHalf)) >> RoundShift;
        r.index_out     = w.elem_index;
        r.phase_out     = (in_upper_half(w.elem_index) ? HalfTurn : PhaseW'(0))
                          - rounded[PhaseW-1:0];
        r.amplitude_out = drive_amp;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one register write, then the enable drops again
    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            RegFocusX:    focal_x     = value[CoordW-1:0];
            RegFocusY:    focal_y     = value[CoordW-1:0];
            RegFocusZ:    focal_z     = value[CoordW-1:0];
            RegInvWave:   turns_per_m = value[InvW-1:0];
            RegTwinMode:  twin_on     = value[0];
            RegElemCount: elem_count  = value[CountW-1:0];
            RegDriveAmp:  drive_amp   = value[AmpW-1:0];
            default: ;
        endcase
    endtask

    // full setup; unused upper bits of the write data carry junk
    task automatic write_setup(input logic signed [CoordW-1:0] fx,
                               input logic signed [CoordW-1:0] fy,
                               input logic signed [CoordW-1:0] fz,
                               input logic [InvW-1:0]          inv,
                               input logic                     twin,
                               input logic [CountW-1:0]        count,
                               input logic [AmpW-1:0]          amp);
        write_reg(RegFocusX,    {8'($urandom), fx});
        write_reg(RegFocusY,    {8'($urandom), fy});
        write_reg(RegFocusZ,    {8'($urandom), fz});
        write_reg(RegInvWave,   inv);
        write_reg(RegTwinMode,  {23'($urandom), twin});
        write_reg(RegElemCount, {14'($urandom), count});
        write_reg(RegDriveAmp,  {16'($urandom), amp});
        write_reg(RegSpare,     24'($urandom));
        setups_written++;
    endtask

    // present one word and hold it until the block takes it
    task automatic send_word(input t_in_word w);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        pending_phases.push_back(focus_phase(w));
        words_sent++;
        if (in_upper_half(w.elem_index)) begin
            half_turn_words++;
        end
    endtask

    // sender pause, junk on the data lines while valid is low
    task automatic idle_gap(input int cycles);
        i_valid <= 1'b0;
        i_data  <= InW'({$urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    // block is idle once every predicted word has come out and the pipe is empty
    task automatic drain_pipe;
        i_valid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(input int idx, input int x,
                                           input int y, input int z);
        t_in_word w;
        w.elem_index = IndexW'(idx);
        w.elem_x     = CoordW'(x);
        w.elem_y     = CoordW'(y);
        w.elem_z     = CoordW'(z);
        return w;
    endfunction

    function automatic logic signed [CoordW-1:0] clamp_coord(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return CoordW'(v);
    endfunction

    function automatic logic signed [CoordW-1:0] pick_extreme;
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    // element for the random part: grid scans on array-like setups,
    // otherwise anything, with some near the focus and some on the rails
    function automatic t_in_word next_element(input logic on_grid, input int seq);
        t_in_word w;
        int       jitter;
        jitter = int'($urandom_range(0, 64)) - 32;
        w.elem_index = ($urandom_range(0, 3) == 0) ? IndexW'($urandom) : IndexW'(seq);
        case ($urandom_range(0, 9))
            0, 1: begin
                w.elem_x = clamp_coord(int'(focal_x) + int'($urandom_range(0, 600)) - 300);
                w.elem_y = clamp_coord(int'(focal_y) + int'($urandom_range(0, 600)) - 300);
                w.elem_z = clamp_coord(int'(focal_z) + int'($urandom_range(0, 600)) - 300);
            end
            2: begin
                w.elem_x = pick_extreme();
                w.elem_y = pick_extreme();
                w.elem_z = pick_extreme();
            end
            3, 4, 5, 6: begin
                if (on_grid) begin
                    w.elem_x = clamp_coord((seq % 16 - 8) * GridPitch + jitter);
                    w.elem_y = clamp_coord(((seq / 16) % 16 - 8) * GridPitch - jitter);
                    w.elem_z = clamp_coord(jitter);
                end else begin
                    w.elem_x = CoordW'($urandom);
                    w.elem_y = CoordW'($urandom);
                    w.elem_z = CoordW'($urandom);
                end
            end
            default: begin
                w.elem_x = CoordW'($urandom);
                w.elem_y = CoordW'($urandom);
                w.elem_z = CoordW'($urandom);
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver stall pattern
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_phases.size() == 0) begin
                $error("unexpected result word: index_out %0d phase_out %0h",
                       o_data.index_out, o_data.phase_out);
                fail_count++;
            end else begin
                want = pending_phases.pop_front();
                results_checked++;
                if (o_data.index_out !== want.index_out) begin
                    $error("index_out: expected %0d, got %0d",
                           want.index_out, o_data.index_out);
                    fail_count++;
                end
                if (o_data.phase_out !== want.phase_out) begin
                    $error("phase_out: expected %0h, got %0h",
                           want.phase_out, o_data.phase_out);
                    fail_count++;
                end
                if (o_data.amplitude_out !== want.amplitude_out) begin
                    $error("amplitude_out: expected %0d, got %0d",
                           want.amplitude_out, o_data.amplitude_out);
                    fail_count++;
                end
            end
        end
    end

    // the receiver picks a new stall behavior at random whenever the low byte of stall_tick is zero
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[7:0] == 8'd0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= stall_tick[2] & stall_tick[0];
        endcase
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset configuration: origin, focus itself, both corners of the space
    task automatic test_reset_defaults;
        send_word(make_word(0, 0, 0, 0));
        send_word(make_word(511, 0, 0, 3277));
        send_word(make_word(256, 32767, 32767, 32767));
        send_word(make_word(255, -32768, -32768, -32768));
        send_word(make_word(1, -32768, 32767, -1));
        drain_pipe();
    endtask

    // register extremes: longest path, zero and full inverse wavelength,
    // count zero (all upper half) and a count clamped to the array size
    task automatic test_register_extremes;
        write_setup(16'sh7fff, 16'sh8000, 16'sh8000, 24'hffffff, 1'b0, 10'd512, 8'd0);
        send_word(make_word(0, -32768, 32767, 32767));
        send_word(make_word(300, 32767, -32768, -32768));
        drain_pipe();
        write_setup(16'sh8000, 16'sh7fff, 16'sh0000, 24'd0, 1'b1, 10'd0, 8'd255);
        send_word(make_word(0, 1234, -4321, 99));
        send_word(make_word(511, 32767, -32768, 0));
        drain_pipe();
        write_setup(16'sh0000, 16'sh0000, 16'sh0000, 24'd1, 1'b1, 10'd1023, 8'h80);
        send_word(make_word(255, 32767, 32767, 32767));
        send_word(make_word(256, -32768, -32768, -32768));
        drain_pipe();
    endtask

    // twin split around count / 2, indexes past the count, count of one
    task automatic test_twin_halves;
        write_setup(FocusXReset, FocusYReset, FocusZReset, InvReset, 1'b1, 10'd100, 8'ha5);
        send_word(make_word(0, 655, -655, 0));
        send_word(make_word(49, 655, -655, 0));
        send_word(make_word(50, 655, -655, 0));
        send_word(make_word(51, -1310, 1310, 5));
        send_word(make_word(99, 0, 0, 0));
        send_word(make_word(100, 0, 0, 0));
        send_word(make_word(511, 0, 0, 0));
        drain_pipe();
        write_reg(RegElemCount, 24'd1);
        send_word(make_word(0, 100, 200, 300));
        drain_pipe();
    endtask

    // a write to the spare index must leave every register alone
    task automatic test_spare_register;
        write_reg(RegSpare, 24'hffffff);
        send_word(make_word(7, 3000, -3000, 0));
        send_word(make_word(60, -5000, 2000, 1000));
        drain_pipe();
    endtask

    // random setups, each followed by a stream of elements, in bursts but for the second setup
    task automatic test_random_setups;
        logic signed [CoordW-1:0] fx;
        logic signed [CoordW-1:0] fy;
        logic signed [CoordW-1:0] fz;
        logic [InvW-1:0]          inv;
        logic                     twin;
        logic [CountW-1:0]        count;
        logic [AmpW-1:0]          amp;
        logic                     on_grid;
        int                       burst_left;
        for (int s = 0; s < SetupCount; s++) begin
            on_grid = 1'b0;
            amp     = AmpW'($urandom);
            case (s % 4)
                0: begin
                    // anything the fields allow
                    fx    = CoordW'($urandom);
                    fy    = CoordW'($urandom);
                    fz    = CoordW'($urandom);
                    inv   = InvW'($urandom);
                    twin  = 1'($urandom);
                    count = CountW'($urandom);
                end
                1, 3: begin
                    // array-like: focus above a flat grid, near the reset wavelength
                    on_grid = 1'b1;
                    fx    = clamp_coord(int'($urandom_range(0, 16384)) - 8192);
                    fy    = clamp_coord(int'($urandom_range(0, 16384)) - 8192);
                    fz    = clamp_coord(int'($urandom_range(3000, 20000)));
                    inv   = InvW'(int'(InvReset) + int'($urandom_range(0, 200000)) - 100000);
                    twin  = (s % 4 == 3);
                    count = (s % 4 == 3) ? CountW'($urandom_range(1, 512)) : CountReset;
                end
                default: begin
                    // rails of every register
                    fx = pick_extreme();
                    fy = pick_extreme();
                    fz = pick_extreme();
                    case ($urandom_range(0, 2))
                        0:       inv = '0;
                        1:       inv = '1;
                        default: inv = InvW'($urandom);
                    endcase
                    twin = 1'b1;
                    case ($urandom_range(0, 6))
                        0:       count = 10'd0;
                        1:       count = 10'd1;
                        2:       count = 10'd2;
                        3:       count = 10'd511;
                        4:       count = 10'd512;
                        5:       count = 10'd513;
                        default: count = 10'd1023;
                    endcase
                    amp = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
                end
            endcase
            write_setup(fx, fy, fz, inv, twin, count, amp);
            burst_left = $urandom_range(1, 40);
            for (int k = 0; k < WordsPerSetup; k++) begin
                send_word(next_element(on_grid, k));
                // the second setup streams without sender pauses
                if (s != 1) begin
                    if (burst_left == 0) begin
                        idle_gap($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end
            end
            drain_pipe();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        focal_x     = FocusXReset;
        focal_y     = FocusYReset;
        focal_z     = FocusZReset;
        turns_per_m = InvReset;
        twin_on     = 1'b0;
        elem_count  = CountReset;
        drive_amp   = AmpReset;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_twin_halves();
        test_spare_register();
        test_random_setups();

        $display("covered %0d element words over %0d register setups, %0d results checked",
                 words_sent, setups_written, results_checked);
        $display("%0d words carried the twin half turn, %0d mismatches",
                 half_turn_words, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("watchdog expired with %0d result words outstanding", pending_phases.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: array_focus_phase.f
rtl/core/afp_pkg.sv
rtl/core/afp_dist_sq.sv
rtl/core/afp_root_cell.sv
rtl/core/afp_phase.sv
rtl/core/array_focus_phase.sv
sim/array_focus_phase_tb.sv
